// ----- design/rmba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: shared package
// Field widths, configuration register indexes, parameter defaults and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rmba_pkg;

  // Payload and configuration widths.
  localparam int CFG_W       = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 8;
  localparam int BLOCK_IDX_W = 9;

  // Parameter defaults for the top level.
  localparam int BLOCK_SIZE_DEF       = 9;
  localparam int MAX_FRAME_WIDTH_DEF  = 4096;
  localparam int MAX_FRAME_HEIGHT_DEF = 4096;

  // Configuration values after reset.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_REGION_LEFT   = 3'd2,
    REG_REGION_TOP    = 3'd3,
    REG_REGION_WIDTH  = 3'd4,
    REG_REGION_HEIGHT = 3'd5
  } cfg_reg_t;

  // Operand choice for the shared divide-by-block-size unit.
  typedef enum logic [2:0] {
    DIV_NONE     = 3'd0,
    DIV_REGION_W = 3'd1,
    DIV_REGION_H = 3'd2,
    DIV_INSIDE_X = 3'd3,
    DIV_INSIDE_Y = 3'd4,
    DIV_BLOCK_X  = 3'd5,
    DIV_BLOCK_Y  = 3'd6
  } div_op_t;

  typedef struct packed {
    logic    clear_step;
    div_op_t div_op;
    logic    eval;
    logic    weigh;
    logic    scale;
    logic    update;
    logic    mean;
    logic    load_out;
  } rmba_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic keep;
    logic at_end;
    logic out_free;
  } rmba_status_t;

endpackage

// ----- design/rmba_pixel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: pixel channel
// Valid/ready channel carrying one BGR pixel with its column and row.
// ----------------------------------------------------------------------------
interface rmba_pixel_if import rmba_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_blue;
  logic [COLOR_W-1:0] pixel_green;
  logic [COLOR_W-1:0] pixel_red;
  logic [COORD_W-1:0] pixel_column;
  logic [COORD_W-1:0] pixel_row;

  modport source (
    output valid, pixel_blue, pixel_green, pixel_red, pixel_column, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, pixel_blue, pixel_green, pixel_red, pixel_column, pixel_row,
    output ready
  );

endinterface

// ----- design/rmba_block_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: block result channel
// Valid/ready channel carrying one block's indices and mean color.
// ----------------------------------------------------------------------------
interface rmba_block_if import rmba_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [BLOCK_IDX_W-1:0] block_row;
  logic [BLOCK_IDX_W-1:0] block_column;
  logic [COLOR_W-1:0]     average_blue;
  logic [COLOR_W-1:0]     average_green;
  logic [COLOR_W-1:0]     average_red;
  logic                   last_block;

  modport source (
    output valid, block_row, block_column, average_blue, average_green, average_red,
    output last_block,
    input  ready
  );

  modport sink (
    input  valid, block_row, block_column, average_blue, average_green, average_red,
    input  last_block,
    output ready
  );

endinterface

// ----- design/rmba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: controller
// One-hot sequencer that clears the sum memory after reset and then walks
// each accepted pixel through the datapath steps.
// ----------------------------------------------------------------------------
module rmba_ctrl import rmba_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rmba_status_t status,
  output rmba_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_DIV_RW = 15'b000000000000100,
    S_DIV_RH = 15'b000000000001000,
    S_DIV_IX = 15'b000000000010000,
    S_DIV_IY = 15'b000000000100000,
    S_DIV_BX = 15'b000000001000000,
    S_DIV_BY = 15'b000000010000000,
    S_LAND   = 15'b000000100000000,
    S_EVAL   = 15'b000001000000000,
    S_WEIGH  = 15'b000010000000000,
    S_SCALE  = 15'b000100000000000,
    S_UPDATE = 15'b001000000000000,
    S_MEAN   = 15'b010000000000000,
    S_FINISH = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = DIV_NONE;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIV_RW;
        end
      end
      S_DIV_RW: begin
        cmd.div_op = DIV_REGION_W;
        state_next = S_DIV_RH;
      end
      S_DIV_RH: begin
        cmd.div_op = DIV_REGION_H;
        state_next = S_DIV_IX;
      end
      S_DIV_IX: begin
        cmd.div_op = DIV_INSIDE_X;
        state_next = S_DIV_IY;
      end
      S_DIV_IY: begin
        cmd.div_op = DIV_INSIDE_Y;
        state_next = S_DIV_BX;
      end
      S_DIV_BX: begin
        cmd.div_op = DIV_BLOCK_X;
        state_next = S_DIV_BY;
      end
      S_DIV_BY: begin
        cmd.div_op = DIV_BLOCK_Y;
        state_next = S_LAND;
      end
      S_LAND: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.keep ? S_WEIGH : S_IDLE;
      end
      S_WEIGH: begin
        cmd.weigh  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.at_end) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/rmba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: datapath
// Configuration registers, divide-by-block-size unit, per-block-column sum
// memory, weighting, saturating accumulation, rounding means and the
// output register.
// ----------------------------------------------------------------------------
module rmba_dp import rmba_pkg::*; #(
  parameter int BLOCK_SIZE       = BLOCK_SIZE_DEF,
  parameter int MAX_FRAME_WIDTH  = MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = MAX_FRAME_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   pixel_accept,
  input  logic [COLOR_W-1:0]     pixel_blue,
  input  logic [COLOR_W-1:0]     pixel_green,
  input  logic [COLOR_W-1:0]     pixel_red,
  input  logic [COORD_W-1:0]     pixel_column,
  input  logic [COORD_W-1:0]     pixel_row,
  input  rmba_cmd_t              cmd,
  output rmba_status_t           status,
  rmba_block_if.source           blocks
);

  localparam int SUM_DEPTH   = MAX_FRAME_WIDTH / BLOCK_SIZE;
  localparam int ROW_LIMIT   = MAX_FRAME_HEIGHT / BLOCK_SIZE;
  localparam int MEM_DEPTH   = (SUM_DEPTH > 1) ? SUM_DEPTH : 2;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int AREA        = BLOCK_SIZE * BLOCK_SIZE;
  localparam int SUM_MAX     = AREA * 255;
  localparam int SUM_W       = $clog2(SUM_MAX + 1);
  localparam int WGT_W       = $clog2(BLOCK_SIZE + 1);
  localparam int AREA_W      = $clog2(AREA + 1);
  localparam int POS_W       = CFG_W + 1;

  // Division by BLOCK_SIZE: multiply by a rounded-up reciprocal, then shift.
  localparam int DIV_SHIFT   = CFG_W + $clog2(BLOCK_SIZE);
  localparam longint unsigned DIV_MULT = (longint'(1) << DIV_SHIFT) / BLOCK_SIZE + 1;
  localparam int DIV_MULT_W  = CFG_W + 2;
  localparam int DIV_PROD_W  = CFG_W + DIV_MULT_W;

  // Division of a rounded sum by the block area, the same way.
  localparam int MEAN_IN_W   = SUM_W + 1;
  localparam int MEAN_SHIFT  = MEAN_IN_W + $clog2(AREA);
  localparam longint unsigned MEAN_MULT = (longint'(1) << MEAN_SHIFT) / AREA + 1;
  localparam int MEAN_MULT_W = MEAN_IN_W + 2;
  localparam int MEAN_PROD_W = MEAN_IN_W + MEAN_MULT_W;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  // Configuration registers.
  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [COORD_W-1:0] region_left;
  logic [COORD_W-1:0] region_top;
  logic [CFG_W-1:0]   region_width;
  logic [CFG_W-1:0]   region_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      region_left   <= '0;
      region_top    <= '0;
      region_width  <= '0;
      region_height <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_REGION_LEFT:   region_left   <= cfg_data[COORD_W-1:0];
        REG_REGION_TOP:    region_top    <= cfg_data[COORD_W-1:0];
        REG_REGION_WIDTH:  region_width  <= cfg_data;
        REG_REGION_HEIGHT: region_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective frame size, limited to the supported maximum.
  logic [CFG_W-1:0] fw;
  logic [CFG_W-1:0] fh;

  assign fw = ({1'b0, frame_width} > POS_W'(MAX_FRAME_WIDTH)) ?
              CFG_W'(MAX_FRAME_WIDTH) : frame_width;
  assign fh = ({1'b0, frame_height} > POS_W'(MAX_FRAME_HEIGHT)) ?
              CFG_W'(MAX_FRAME_HEIGHT) : frame_height;

  // Captured pixel.
  logic [COLOR_W-1:0] in_blue;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_red;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      in_blue  <= pixel_blue;
      in_green <= pixel_green;
      in_red   <= pixel_red;
      in_col   <= pixel_column;
      in_row   <= pixel_row;
    end
  end

  // Shared divider: one operand a cycle, the quotient lands in the following cycle.
  logic [CFG_W-1:0]      div_in;
  logic [DIV_PROD_W-1:0] div_prod;
  div_op_t               div_tag;
  logic [CFG_W-1:0]      quot;
  logic [CFG_W-1:0]      q_rw;
  logic [CFG_W-1:0]      q_rh;
  logic [CFG_W-1:0]      q_ix;
  logic [CFG_W-1:0]      q_iy;
  logic [CFG_W-1:0]      q_bx;
  logic [CFG_W-1:0]      q_by;

  always_comb begin
    case (cmd.div_op)
      DIV_REGION_W: div_in = region_width;
      DIV_REGION_H: div_in = region_height;
      DIV_INSIDE_X: div_in = fw - CFG_W'(1) - CFG_W'(region_left);
      DIV_INSIDE_Y: div_in = fh - CFG_W'(1) - CFG_W'(region_top);
      DIV_BLOCK_X:  div_in = CFG_W'(in_col) - CFG_W'(region_left);
      DIV_BLOCK_Y:  div_in = CFG_W'(in_row) - CFG_W'(region_top);
      default:      div_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    div_prod <= DIV_PROD_W'(div_in) * DIV_PROD_W'(DIV_MULT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_tag <= DIV_NONE;
    end else begin
      div_tag <= cmd.div_op;
    end
  end

  assign quot = CFG_W'(div_prod >> DIV_SHIFT);

  always_ff @(posedge clk) begin
    case (div_tag)
      DIV_REGION_W: q_rw <= quot;
      DIV_REGION_H: q_rh <= quot;
      DIV_INSIDE_X: q_ix <= quot;
      DIV_INSIDE_Y: q_iy <= quot;
      DIV_BLOCK_X:  q_bx <= quot;
      DIV_BLOCK_Y:  q_by <= quot;
      default: begin
      end
    endcase
  end

  // Block counts and the acceptance test for the pixel.
  logic [CFG_W-1:0] cap_x;
  logic [CFG_W-1:0] cap_y;
  logic [CFG_W-1:0] inside_x;
  logic [CFG_W-1:0] inside_y;
  logic [CFG_W-1:0] nx;
  logic [CFG_W-1:0] ny;
  logic             in_frame;
  logic             keep;
  logic             last_hit;
  logic [POS_W-1:0] xs_calc;
  logic [POS_W-1:0] ys_calc;

  always_comb begin
    cap_x    = (q_rw > CFG_W'(SUM_DEPTH)) ? CFG_W'(SUM_DEPTH) : q_rw;
    cap_y    = (q_rh > CFG_W'(ROW_LIMIT)) ? CFG_W'(ROW_LIMIT) : q_rh;
    inside_x = q_ix + CFG_W'(1);
    inside_y = q_iy + CFG_W'(1);
    if (CFG_W'(region_left) >= fw) begin
      nx = '0;
    end else begin
      nx = (cap_x < inside_x) ? cap_x : inside_x;
    end
    if (CFG_W'(region_top) >= fh) begin
      ny = '0;
    end else begin
      ny = (cap_y < inside_y) ? cap_y : inside_y;
    end
    in_frame = (CFG_W'(in_col) < fw) && (CFG_W'(in_row) < fh) &&
               (in_col >= region_left) && (in_row >= region_top);
    keep     = in_frame && (q_bx < nx) && (q_by < ny) && (q_bx < CFG_W'(SUM_DEPTH));
    last_hit = (q_by == ny - CFG_W'(1)) && (q_bx == nx - CFG_W'(1));
    xs_calc  = POS_W'(region_left) + POS_W'(q_bx) * POS_W'(BLOCK_SIZE);
    ys_calc  = POS_W'(region_top) + POS_W'(q_by) * POS_W'(BLOCK_SIZE);
  end

  logic [POS_W-1:0] xs;
  logic [POS_W-1:0] ys;
  logic             last_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      xs     <= xs_calc;
      ys     <= ys_calc;
      last_r <= last_hit;
    end
  end

  // Edge weighting, restart and block-end detection.
  logic [POS_W-1:0] col_p;
  logic [POS_W-1:0] row_p;
  logic [POS_W-1:0] fw_last;
  logic [POS_W-1:0] fh_last;
  logic [POS_W-1:0] xs_tail;
  logic [POS_W-1:0] ys_tail;
  logic [POS_W-1:0] xe;
  logic [POS_W-1:0] ye;
  logic [POS_W-1:0] wx_full;
  logic [POS_W-1:0] wy_full;
  logic [WGT_W-1:0] wx;
  logic [WGT_W-1:0] wy;

  always_comb begin
    col_p   = POS_W'(in_col);
    row_p   = POS_W'(in_row);
    fw_last = POS_W'(fw) - POS_W'(1);
    fh_last = POS_W'(fh) - POS_W'(1);
    xs_tail = xs + POS_W'(BLOCK_SIZE - 1);
    ys_tail = ys + POS_W'(BLOCK_SIZE - 1);
    xe      = (xs_tail > fw_last) ? fw_last : xs_tail;
    ye      = (ys_tail > fh_last) ? fh_last : ys_tail;
    wx_full = xs + POS_W'(BLOCK_SIZE) - col_p;
    wy_full = ys + POS_W'(BLOCK_SIZE) - row_p;
    wx      = (col_p == fw_last) ? WGT_W'(wx_full) : WGT_W'(1);
    wy      = (row_p == fh_last) ? WGT_W'(wy_full) : WGT_W'(1);
  end

  logic [AREA_W-1:0] weight;
  logic              restart;
  logic              at_end;

  always_ff @(posedge clk) begin
    if (cmd.weigh) begin
      weight  <= AREA_W'(wx) * AREA_W'(wy);
      restart <= (col_p == xs) && (row_p == ys);
      at_end  <= (col_p == xe) && (row_p == ye);
    end
  end

  logic [SUM_W-1:0] add_blue;
  logic [SUM_W-1:0] add_green;
  logic [SUM_W-1:0] add_red;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      add_blue  <= SUM_W'(weight) * SUM_W'(in_blue);
      add_green <= SUM_W'(weight) * SUM_W'(in_green);
      add_red   <= SUM_W'(weight) * SUM_W'(in_red);
    end
  end

  // Sum memory: one entry per block column, cleared by a sweep after reset.
  sums_t            sum_mem [MEM_DEPTH];
  sums_t            rd_sums;
  sums_t            new_sums;
  sums_t            sums_r;
  logic [ADDR_W-1:0] clr_addr;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  sums_t            mem_wdata;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rd_sums <= sum_mem[q_bx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] base,
                                               input logic [SUM_W-1:0] add);
    logic [SUM_W:0] total;
    total = {1'b0, base} + {1'b0, add};
    return (total > (SUM_W + 1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : total[SUM_W-1:0];
  endfunction

  always_comb begin
    new_sums.blue  = sat_add(restart ? '0 : rd_sums.blue, add_blue);
    new_sums.green = sat_add(restart ? '0 : rd_sums.green, add_green);
    new_sums.red   = sat_add(restart ? '0 : rd_sums.red, add_red);
    mem_we         = cmd.clear_step || cmd.update;
    mem_waddr      = cmd.clear_step ? clr_addr : q_bx[ADDR_W-1:0];
    mem_wdata      = cmd.clear_step ? '0 : new_sums;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sums_r <= new_sums;
    end
  end

  // Rounded means: (sum + area/2) / area.
  logic [MEAN_PROD_W-1:0] mean_blue;
  logic [MEAN_PROD_W-1:0] mean_green;
  logic [MEAN_PROD_W-1:0] mean_red;

  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      mean_blue  <= MEAN_PROD_W'(MEAN_IN_W'(sums_r.blue) + MEAN_IN_W'(AREA / 2)) *
                    MEAN_PROD_W'(MEAN_MULT);
      mean_green <= MEAN_PROD_W'(MEAN_IN_W'(sums_r.green) + MEAN_IN_W'(AREA / 2)) *
                    MEAN_PROD_W'(MEAN_MULT);
      mean_red   <= MEAN_PROD_W'(MEAN_IN_W'(sums_r.red) + MEAN_IN_W'(AREA / 2)) *
                    MEAN_PROD_W'(MEAN_MULT);
    end
  end

  // Output register.
  logic                   out_valid;
  logic [BLOCK_IDX_W-1:0] out_row;
  logic [BLOCK_IDX_W-1:0] out_column;
  logic [COLOR_W-1:0]     out_blue;
  logic [COLOR_W-1:0]     out_green;
  logic [COLOR_W-1:0]     out_red;
  logic                   out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (blocks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row    <= q_by[BLOCK_IDX_W-1:0];
      out_column <= q_bx[BLOCK_IDX_W-1:0];
      out_blue   <= COLOR_W'(mean_blue >> MEAN_SHIFT);
      out_green  <= COLOR_W'(mean_green >> MEAN_SHIFT);
      out_red    <= COLOR_W'(mean_red >> MEAN_SHIFT);
      out_last   <= last_r;
    end
  end

  assign blocks.valid         = out_valid;
  assign blocks.block_row     = out_row;
  assign blocks.block_column  = out_column;
  assign blocks.average_blue  = out_blue;
  assign blocks.average_green = out_green;
  assign blocks.average_red   = out_red;
  assign blocks.last_block    = out_last;

  assign status.clear_done = (clr_addr == ADDR_W'(MEM_DEPTH - 1));
  assign status.keep       = keep;
  assign status.at_end     = at_end;
  assign status.out_free   = !out_valid || blocks.ready;

endmodule

// ----- design/region_mosaic_block_average_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average unit
// Tiles a frame region with square blocks, accumulates BGR sums per block
// column from a raster pixel stream and emits each block's rounded mean.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Transaction
//   -------   ---------  -------------------  ---------------------------------
//   pixels    in         valid/ready          one BGR pixel with column and row
//   blocks    out        valid/ready          one block's indices, means, last
//   cfg       in         write enable only    one register write, no read-back
//
// Every pixel passes six times through the single divide-by-block-size
// multiplier and then the acceptance test, which drops it when it is outside
// the frame, the region or its whole blocks; a pixel that contributes to a
// block also goes through the sum memory read-modify-write and the rounding
// multipliers. The next pixel is accepted only after these steps.
// After reset a clearing sweep zeroes the sum memory, one entry per cycle,
// MAX_FRAME_WIDTH / BLOCK_SIZE entries (455 at the defaults); no pixel is
// taken during the sweep. Configuration writes are taken at any time.
// A finished block waits in the output register; the next pixel is accepted
// meanwhile, and only a second block result stalls until the first is taken.
// ----------------------------------------------------------------------------
module region_mosaic_block_average_unit import rmba_pkg::*; #(
  parameter int BLOCK_SIZE       = BLOCK_SIZE_DEF,
  parameter int MAX_FRAME_WIDTH  = MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = MAX_FRAME_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  rmba_pixel_if.sink             pixels,
  rmba_block_if.source           blocks
);

  rmba_cmd_t    ctrl_cmd;
  rmba_status_t dp_status;
  logic         pixel_accept;

  // A pixel transaction completes when both sides agree on the same edge.
  assign pixel_accept = pixels.valid && pixels.ready;

  // The controller sequences every step; it never touches payload.
  rmba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  // The datapath holds configuration, the sum memory and the output register.
  rmba_dp #(
    .BLOCK_SIZE       (BLOCK_SIZE),
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_accept (pixel_accept),
    .pixel_blue   (pixels.pixel_blue),
    .pixel_green  (pixels.pixel_green),
    .pixel_red    (pixels.pixel_red),
    .pixel_column (pixels.pixel_column),
    .pixel_row    (pixels.pixel_row),
    .cmd          (ctrl_cmd),
    .status       (dp_status),
    .blocks       (blocks)
  );

  // No pixel may enter while the sum memory is still being cleared.
  assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.clear_step |-> !pixels.ready)
    else $error("pixel channel ready during sum memory clear");

  // A block result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.load_out |-> dp_status.out_free)
    else $error("output register overwritten before its transaction");

  // A loaded result is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.load_out |=> blocks.valid)
    else $error("loaded block result not presented");

  // Only one pixel is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    pixel_accept |=> !pixels.ready)
    else $error("second pixel accepted while one is in flight");

endmodule

// ----- test/rmba_mean_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: block mean checker
// Watches the pixel, block and configuration ports. It keeps its own copy of
// the registers and of the per-block-column color sums, and predicts every
// block mean. Each block transaction is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module rmba_mean_checker import rmba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  rmba_pixel_if                  pixels,
  rmba_block_if                  blocks,
  output int unsigned            failures,
  output int unsigned            blocks_checked,
  output int unsigned            blocks_pending,
  output int unsigned            pixels_used
);

  localparam int unsigned BS           = BLOCK_SIZE_DEF;
  localparam int unsigned MAX_W        = MAX_FRAME_WIDTH_DEF;
  localparam int unsigned MAX_H        = MAX_FRAME_HEIGHT_DEF;
  localparam int unsigned COLUMN_SLOTS = MAX_W / BS;
  localparam int unsigned ROW_SLOTS    = MAX_H / BS;
  localparam int unsigned AREA         = BS * BS;
  localparam int unsigned SUM_CEIL     = AREA * 255;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [BLOCK_IDX_W-1:0] block_row;
    logic [BLOCK_IDX_W-1:0] block_column;
    logic [COLOR_W-1:0]     average_blue;
    logic [COLOR_W-1:0]     average_green;
    logic [COLOR_W-1:0]     average_red;
    logic                   last_block;
  } block_mean_t;

  logic [CFG_W-1:0]   frame_w;
  logic [CFG_W-1:0]   frame_h;
  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [CFG_W-1:0]   region_w;
  logic [CFG_W-1:0]   region_h;
  logic [14:0]        blue_sum [COLUMN_SLOTS];
  logic [14:0]        green_sum[COLUMN_SLOTS];
  logic [14:0]        red_sum  [COLUMN_SLOTS];
  block_mean_t        means_due[$];

  // Whole blocks along one axis that start inside the frame.
  function automatic int unsigned blocks_along(input int unsigned origin, extent, cap, frame);
    int unsigned n;
    n = extent / BS;
    if (n > cap) n = cap;
    if (origin >= frame) return 0;
    if ((frame - 1 - origin) / BS + 1 < n) n = (frame - 1 - origin) / BS + 1;
    return n;
  endfunction

  function automatic logic [14:0] add_capped(input logic [14:0] sum, input bit restart,
                                             input int unsigned add);
    int unsigned total;
    total = (restart ? 0 : int'(sum)) + add;
    return (total > SUM_CEIL) ? 15'(SUM_CEIL) : 15'(total);
  endfunction

  function automatic logic [COLOR_W-1:0] rounded_mean(input logic [14:0] sum);
    return COLOR_W'((int'(sum) + AREA / 2) / AREA);
  endfunction

  // Folds one pixel into its block column and returns 1 with the block mean
  // when this pixel is the last one that the block needs.
  function automatic bit mosaic_step(input logic [COLOR_W-1:0] b, g, r,
                                     input logic [COORD_W-1:0] col, row,
                                     output block_mean_t res);
    int unsigned fw, fh, nx, ny, bx, by, xs, ys, xe, ye, w;
    bit restart;
    fw = (frame_w > MAX_W) ? MAX_W : frame_w;
    fh = (frame_h > MAX_H) ? MAX_H : frame_h;
    if (col >= fw || row >= fh || col < left || row < top) return 0;
    nx = blocks_along(left, region_w, COLUMN_SLOTS, fw);
    ny = blocks_along(top, region_h, ROW_SLOTS, fh);
    bx = (col - left) / BS;
    by = (row - top) / BS;
    if (bx >= nx || by >= ny || bx >= COLUMN_SLOTS) return 0;
    pixels_used++;
    xs = left + bx * BS;
    ys = top + by * BS;
    // An edge pixel stands in for the samples that fall beyond the frame.
    w = ((col == fw - 1) ? xs + BS - col : 1) * ((row == fh - 1) ? ys + BS - row : 1);
    restart = (col == xs) && (row == ys);
    blue_sum[bx]  = add_capped(blue_sum[bx], restart, w * b);
    green_sum[bx] = add_capped(green_sum[bx], restart, w * g);
    red_sum[bx]   = add_capped(red_sum[bx], restart, w * r);
    xe = (xs + BS - 1 > fw - 1) ? fw - 1 : xs + BS - 1;
    ye = (ys + BS - 1 > fh - 1) ? fh - 1 : ys + BS - 1;
    if (col != xe || row != ye) return 0;
    res.block_row     = BLOCK_IDX_W'(by);
    res.block_column  = BLOCK_IDX_W'(bx);
    res.average_blue  = rounded_mean(blue_sum[bx]);
    res.average_green = rounded_mean(green_sum[bx]);
    res.average_red   = rounded_mean(red_sum[bx]);
    res.last_block    = (by == ny - 1) && (bx == nx - 1);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    block_mean_t seen;
    block_mean_t want;
    if (rst) begin
      frame_w  = FRAME_WIDTH_RST;
      frame_h  = FRAME_HEIGHT_RST;
      left     = '0;
      top      = '0;
      region_w = '0;
      region_h = '0;
      for (int i = 0; i < COLUMN_SLOTS; i++) begin
        blue_sum[i]  = '0;
        green_sum[i] = '0;
        red_sum[i]   = '0;
      end
      means_due.delete();
      failures       = 0;
      blocks_checked = 0;
      pixels_used    = 0;
    end else begin
      // Results first: a block taken on this edge can never come from the
      // pixel taken on the same edge.
      if (blocks.valid === 1'b1 && blocks.ready === 1'b1) begin
        seen.block_row     = blocks.block_row;
        seen.block_column  = blocks.block_column;
        seen.average_blue  = blocks.average_blue;
        seen.average_green = blocks.average_green;
        seen.average_red   = blocks.average_red;
        seen.last_block    = blocks.last_block;
        if (means_due.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: unexpected block row %0d col %0d bgr %0d/%0d/%0d last %0b",
                     $realtime, seen.block_row, seen.block_column, seen.average_blue,
                     seen.average_green, seen.average_red, seen.last_block);
        end else begin
          want = means_due.pop_front();
          blocks_checked++;
          if (seen !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display({"%0t: block mismatch, expected row %0d col %0d bgr %0d/%0d/%0d",
                        " last %0b, got row %0d col %0d bgr %0d/%0d/%0d last %0b"},
                       $realtime, want.block_row, want.block_column, want.average_blue,
                       want.average_green, want.average_red, want.last_block,
                       seen.block_row, seen.block_column, seen.average_blue,
                       seen.average_green, seen.average_red, seen.last_block);
          end
        end
      end
      if (pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
        if (mosaic_step(pixels.pixel_blue, pixels.pixel_green, pixels.pixel_red,
                        pixels.pixel_column, pixels.pixel_row, want))
          means_due.push_back(want);
      end
      if (cfg_write_en === 1'b1) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:   frame_w  = cfg_data;
          REG_FRAME_HEIGHT:  frame_h  = cfg_data;
          REG_REGION_LEFT:   left     = cfg_data[COORD_W-1:0];
          REG_REGION_TOP:    top      = cfg_data[COORD_W-1:0];
          REG_REGION_WIDTH:  region_w = cfg_data;
          REG_REGION_HEIGHT: region_h = cfg_data;
          default: ;
        endcase
      end
    end
    blocks_pending = means_due.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region mosaic block average: testbench top
// Drives configuration and raster pixel streams into the unit, pulls block
// results with random back-pressure, and lets the block mean checker decide
// whether every result matched.
// ----------------------------------------------------------------------------
module testbench;
  import rmba_pkg::*;

  // The limit covers the slowest legal run: the pixels up to the ceiling of 3000
  // and the window then in progress, each behind the longest input gap, its
  // processing and the longest output hold, plus the configuration and settling
  // time of every frame setting, one long output hold and the clearing sweep
  // after reset, with a wide margin.
  localparam int unsigned LIMIT_NS     = 20_000_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned ITEM_TARGET  = 500;
  localparam int unsigned BLOCK_TARGET = 48;
  localparam int unsigned ITEM_CEILING = 3000;
  localparam int unsigned COORD_MAX    = (1 << COORD_W) - 1;
  localparam int unsigned MAX_W        = MAX_FRAME_WIDTH_DEF;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  rmba_pixel_if pixels ();
  rmba_block_if blocks ();

  int unsigned failures;
  int unsigned blocks_checked;
  int unsigned blocks_pending;
  int unsigned pixels_used;
  int unsigned pixels_sent = 0;
  int unsigned settings_run = 0;

  // When steady is set, neither side inserts idle cycles.
  bit steady = 1'b0;
  // Raised once by the stimulus; the output side then holds ready low.
  bit long_hold_due = 1'b0;

  always #1 clk = ~clk;

  region_mosaic_block_average_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixels       (pixels),
    .blocks       (blocks)
  );

  rmba_mean_checker mean_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixels         (pixels),
    .blocks         (blocks),
    .failures       (failures),
    .blocks_checked (blocks_checked),
    .blocks_pending (blocks_pending),
    .pixels_used    (pixels_used)
  );

  // Idle stretch between transactions: mostly none, often short, rarely long.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Color channel with the extremes weighted up.
  function automatic int unsigned random_channel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // Frame extent for the large settings, including values past the maximum.
  function automatic int unsigned large_extent();
    case ($urandom_range(0, 2))
      0: return MAX_W;
      1: return (1 << CFG_W) - 1;
      default: return $urandom_range(13, MAX_W);
    endcase
  endfunction

  // Drives one pixel transaction from a falling edge and returns on the
  // falling edge after it was taken.
  task automatic send_pixel(input int unsigned b, g, r, col, row);
    int unsigned gap;
    gap = idle_length();
    if (gap > 0) begin
      pixels.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixels.valid        <= 1'b1;
    pixels.pixel_blue   <= COLOR_W'(b);
    pixels.pixel_green  <= COLOR_W'(g);
    pixels.pixel_red    <= COLOR_W'(r);
    pixels.pixel_column <= COORD_W'(col);
    pixels.pixel_row    <= COORD_W'(row);
    do @(posedge clk); while (pixels.ready !== 1'b1);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_W'(value);
    @(negedge clk);
  endtask

  // Registers are only rewritten while the unit is idle, see settle below.
  task automatic configure(input int unsigned fw, fh, lft, tp, rw, rh);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_REGION_LEFT, lft);
    write_reg(REG_REGION_TOP, tp);
    write_reg(REG_REGION_WIDTH, rw);
    write_reg(REG_REGION_HEIGHT, rh);
    cfg_write_en <= 1'b0;
    settings_run++;
  endtask

  // Stops offering pixels, waits for every predicted block, then leaves
  // time for a pixel that makes no block to work its way through.
  task automatic settle();
    pixels.valid <= 1'b0;
    wait (blocks_pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Raster scan over a window. A few pixels are dropped or replaced by
  // random ones, which breaks the block sequence on purpose.
  task automatic stream_window(input int unsigned x0, x1, y0, y1);
    int unsigned pick;
    for (int unsigned y = y0; y <= y1; y++) begin
      for (int unsigned x = x0; x <= x1; x++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) continue;
        if (pick < 6)
          send_pixel(random_channel(), random_channel(), random_channel(),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        else
          send_pixel(random_channel(), random_channel(), random_channel(), x, y);
      end
    end
  endtask

  // Output side: ready toggles with random gaps, and once holds off for a
  // long count of cycles so that the unit backs up into its pixel input.
  initial begin
    int unsigned gap;
    bit held;
    held = 1'b0;
    blocks.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (long_hold_due && !held) begin
        blocks.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end else begin
        blocks.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        gap = idle_length();
        if (gap > 0) begin
          blocks.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned fw, fh, fwe, fhe, lft, tp, rw, rh, kind;
    bit pressed;
    pressed             = 1'b0;
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_index           = REG_FRAME_WIDTH;
    cfg_data            = '0;
    pixels.valid        = 1'b0;
    pixels.pixel_blue   = '0;
    pixels.pixel_green  = '0;
    pixels.pixel_red    = '0;
    pixels.pixel_column = '0;
    pixels.pixel_row    = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reset settings give an empty region, so nothing may come out.
    send_pixel(255, 255, 255, 0, 0);
    settle();

    // A one-pixel frame: its only pixel stands in for all 81 samples, so
    // each in-frame pixel is a complete block. Pixels past the frame edge
    // are ignored.
    configure(1, 1, 0, 0, 9, 9);
    send_pixel(255, 255, 255, 0, 0);
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(1, 128, 254, 0, 0);
    send_pixel(7, 7, 7, 1, 0);
    send_pixel(7, 7, 7, 0, 1);
    settle();

    // Two columns: weights 9 and 72. Blue 4 rounds down and green 5 rounds
    // up. Then the heavy column is repeated without a restart, which first
    // grows the sums and then pins them at their ceiling.
    configure(2, 1, 0, 0, 9, 9);
    send_pixel(4, 5, 0, 0, 0);
    send_pixel(0, 0, 0, 1, 0);
    send_pixel(255, 255, 255, 1, 0);
    send_pixel(255, 255, 255, 1, 0);
    settle();

    // Oversized frame registers fall back to the maximum frame; the corner
    // pixel then forms a whole block on its own. The pixel left of the
    // region is ignored.
    configure((1 << CFG_W) - 1, (1 << CFG_W) - 1, COORD_MAX, COORD_MAX, 9, 9);
    send_pixel(90, 90, 90, COORD_MAX - 1, COORD_MAX);
    send_pixel(170, 85, 60, COORD_MAX, COORD_MAX);
    settle();

    // A zero-size frame uses no pixel at all.
    configure(0, 0, 0, 0, 9, 9);
    send_pixel(9, 9, 9, 0, 0);
    settle();

    // Region far wider than the block column store: the column past the
    // last stored block is ignored, and the last stored block is final.
    configure(MAX_W, 1, 0, 0, (1 << CFG_W) - 1, 9);
    send_pixel(200, 100, 50, COORD_MAX, 0);
    send_pixel(10, 20, 30, 4086, 0);
    send_pixel(40, 50, 60, 4094, 0);
    settle();

    // Random part: one frame setting after another, each followed by a
    // raster stream over the part of the frame where its blocks lie. Small
    // frames dominate so that blocks complete often; the first setting is a
    // tiny frame of at most two by two pixels, and it carries the long output
    // hold.
    while ((pixels_sent < ITEM_TARGET || blocks_checked < BLOCK_TARGET) &&
           pixels_sent < ITEM_CEILING) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = pressed ? $urandom_range(0, 9) : 0;
      if (kind < 2) begin
        fw = $urandom_range(1, 2);
        fh = $urandom_range(1, 2);
        configure(fw, fh, 0, 0, $urandom_range(9, 17), $urandom_range(9, 17));
        if (!pressed) begin
          long_hold_due = 1'b1;
          pressed = 1'b1;
        end
        repeat ($urandom_range(3, 8)) stream_window(0, fw, 0, fh);
      end else if (kind == 2) begin
        fw  = large_extent();
        fh  = large_extent();
        fwe = (fw > MAX_W) ? MAX_W : fw;
        fhe = (fh > MAX_FRAME_HEIGHT_DEF) ? MAX_FRAME_HEIGHT_DEF : fh;
        lft = $urandom_range(0, fwe - 1);
        tp  = $urandom_range(0, fhe - 1);
        configure(fw, fh, lft, tp, $urandom_range(9, (1 << CFG_W) - 1),
                  $urandom_range(9, (1 << CFG_W) - 1));
        stream_window(lft, (lft + 9 > COORD_MAX) ? COORD_MAX : lft + 9,
                      tp, (tp + 9 > COORD_MAX) ? COORD_MAX : tp + 9);
      end else begin
        fw = $urandom_range(1, 10);
        fh = $urandom_range(1, 10);
        rw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 30);
        rh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 30);
        configure(fw, fh, $urandom_range(0, fw), $urandom_range(0, fh), rw, rh);
        stream_window(0, fw, 0, fh);
      end
      settle();
    end

    steady = 1'b0;
    settle();
    $display("Sent %0d pixels (%0d inside whole blocks) under %0d frame settings;",
             pixels_sent, pixels_used, settings_run);
    $display("checked %0d block means, edge-clamped and saturated blocks included.",
             blocks_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- region_mosaic_block_average_unit.f -----
design/rmba_pkg.sv
design/rmba_pixel_if.sv
design/rmba_block_if.sv
design/rmba_ctrl.sv
design/rmba_dp.sv
design/region_mosaic_block_average_unit.sv
test/rmba_mean_checker.sv
test/testbench.sv
